/* rtl/mmpd_pkg.sv */
// Shared constants and types for the min/max plot decimator.
// No dependencies; every other file refers to this package by scoped names.
package mmpd_pkg;

	localparam int MIN_BUCKETS = 16;
	localparam int MAX_BUCKETS = 4096;
	localparam int MAX_SAMPLES = 1048576;

	// positions, counts and bucket figures all fit one width
	localparam int POS_W    = 21;
	localparam int X_W      = 32;
	localparam int Y_W      = 16;
	localparam int GAIN_W   = 16;
	localparam int BIAS_W   = 32;
	localparam int XSUM_W   = X_W + 1;
	localparam int XPT_W    = 48;
	localparam int YOUT_W   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic signed [GAIN_W-1:0] GAIN_ONE = 16'sd256;
	localparam logic signed [Y_W-1:0]    Y_POS_MAX = 16'sh7FFF;
	localparam logic signed [Y_W-1:0]    Y_NEG_MAX = 16'sh8000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SAMPLES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REQ_BUCKETS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_X_GAIN        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_X_BIAS        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_Y_BIAS        = 3'd7;

	// configuration with the window and bucket figures already worked out
	typedef struct packed {
		logic [POS_W-1:0] tot;
		logic [POS_W-1:0] ws;
		logic [POS_W-1:0] we;
		logic [POS_W-1:0] n;
		logic [POS_W-1:0] b;
		logic             win_ok;
		logic signed [GAIN_W-1:0] x_gain;
		logic signed [BIAS_W-1:0] x_bias;
		logic signed [GAIN_W-1:0] y_gain;
		logic signed [BIAS_W-1:0] y_bias;
	} cfg_t;

	// one closed bucket, before scaling
	typedef struct packed {
		logic [XSUM_W-1:0]    x_sum;
		logic signed [Y_W-1:0] y_min;
		logic signed [Y_W-1:0] y_max;
		logic                 last;
	} bucket_t;

endpackage

/* rtl/min_max_plot_decimator.sv */
// Min/max plot decimator top level: config block, bucket tracker, scaler.
// Depends on mmpd_pkg, mmpd_cfg, mmpd_track and mmpd_scale.
//
// channel   direction  handshake              payload
// -------   ---------  ---------------------  ------------------------------------
// in        input      in_valid / in_stall    x_value, y_value
// out       output     out_valid / out_stall  x_point, y_low, y_high, final_bucket
// cfg       input      cfg_wr_en              cfg_index, cfg_data
//
// One sample word accepted per cycle while in_stall is low; a closed bucket passes the input reg,
// tracking reg, multiply reg and output reg after its closing sample is accepted.
// The bucket state update sits between the input and tracking regs.
// Reset clears all control state; no clearing pass is needed.
// Stalls back up stage by stage; empty stages still take words.
module min_max_plot_decimator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [mmpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mmpd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [mmpd_pkg::X_W-1:0]            x_value,
	input  logic signed [mmpd_pkg::Y_W-1:0]     y_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [mmpd_pkg::XPT_W-1:0]   x_point,
	output logic signed [mmpd_pkg::YOUT_W-1:0]  y_low,
	output logic signed [mmpd_pkg::YOUT_W-1:0]  y_high,
	output logic                                final_bucket
);

	mmpd_pkg::cfg_t    cfg;
	mmpd_pkg::bucket_t bkt;
	logic              bkt_valid;
	logic              bkt_stall;

	mmpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mmpd_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_value   (x_value),
		.y_value   (y_value),
		.bkt_valid (bkt_valid),
		.bkt_stall (bkt_stall),
		.bkt       (bkt)
	);

	mmpd_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.bkt_valid    (bkt_valid),
		.bkt_stall    (bkt_stall),
		.bkt          (bkt),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.x_point      (x_point),
		.y_low        (y_low),
		.y_high       (y_high),
		.final_bucket (final_bucket)
	);

endmodule

/* rtl/mmpd_cfg.sv */
// Configuration registers and the derived window / bucket-count figures.
// Depends on mmpd_pkg.
module mmpd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mmpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mmpd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output mmpd_pkg::cfg_t                    cfg
);

	logic [mmpd_pkg::POS_W-1:0]         total_q;
	logic [mmpd_pkg::POS_W-1:0]         start_q;
	logic [mmpd_pkg::POS_W-1:0]         end_q;
	logic [15:0]                        req_q;
	logic signed [mmpd_pkg::GAIN_W-1:0] x_gain_q;
	logic signed [mmpd_pkg::BIAS_W-1:0] x_bias_q;
	logic signed [mmpd_pkg::GAIN_W-1:0] y_gain_q;
	logic signed [mmpd_pkg::BIAS_W-1:0] y_bias_q;

	logic [mmpd_pkg::POS_W-1:0] tot, ws, we, n, req_w, b_clamp, b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			start_q  <= '0;
			end_q    <= '0;
			req_q    <= '0;
			x_gain_q <= mmpd_pkg::GAIN_ONE;
			x_bias_q <= '0;
			y_gain_q <= mmpd_pkg::GAIN_ONE;
			y_bias_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mmpd_pkg::REG_TOTAL_SAMPLES: total_q  <= cfg_data[mmpd_pkg::POS_W-1:0];
				mmpd_pkg::REG_WINDOW_START:  start_q  <= cfg_data[mmpd_pkg::POS_W-1:0];
				mmpd_pkg::REG_WINDOW_END:    end_q    <= cfg_data[mmpd_pkg::POS_W-1:0];
				mmpd_pkg::REG_REQ_BUCKETS:   req_q    <= cfg_data[15:0];
				mmpd_pkg::REG_X_GAIN:        x_gain_q <= $signed(cfg_data[mmpd_pkg::GAIN_W-1:0]);
				mmpd_pkg::REG_X_BIAS:        x_bias_q <= $signed(cfg_data[mmpd_pkg::BIAS_W-1:0]);
				mmpd_pkg::REG_Y_GAIN:        y_gain_q <= $signed(cfg_data[mmpd_pkg::GAIN_W-1:0]);
				mmpd_pkg::REG_Y_BIAS:        y_bias_q <= $signed(cfg_data[mmpd_pkg::BIAS_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		tot = (total_q > mmpd_pkg::POS_W'(mmpd_pkg::MAX_SAMPLES))
			? mmpd_pkg::POS_W'(mmpd_pkg::MAX_SAMPLES) : total_q;
		ws = (start_q < tot) ? start_q : tot;
		we = (end_q < tot) ? end_q : tot;
		n  = we - ws;
		req_w = mmpd_pkg::POS_W'(req_q);
		if (req_w < mmpd_pkg::POS_W'(mmpd_pkg::MIN_BUCKETS))
			b_clamp = mmpd_pkg::POS_W'(mmpd_pkg::MIN_BUCKETS);
		else if (req_w > mmpd_pkg::POS_W'(mmpd_pkg::MAX_BUCKETS))
			b_clamp = mmpd_pkg::POS_W'(mmpd_pkg::MAX_BUCKETS);
		else
			b_clamp = req_w;
		if (req_q == '0)
			b = n;
		else
			b = (b_clamp > n) ? n : b_clamp;

		cfg.tot    = tot;
		cfg.ws     = ws;
		cfg.we     = we;
		cfg.n      = n;
		cfg.b      = b;
		cfg.win_ok = ws < we;
		cfg.x_gain = x_gain_q;
		cfg.x_bias = x_bias_q;
		cfg.y_gain = y_gain_q;
		cfg.y_bias = y_bias_q;
	end

endmodule

/* rtl/mmpd_track.sv */
// Input register, set/bucket tracking state and the closed-bucket register.
// Depends on mmpd_pkg.
module mmpd_track (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mmpd_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mmpd_pkg::X_W-1:0]      x_value,
	input  logic signed [mmpd_pkg::Y_W-1:0] y_value,
	output logic                          bkt_valid,
	input  logic                          bkt_stall,
	output mmpd_pkg::bucket_t             bkt
);

	logic                               valid_s1;
	logic [mmpd_pkg::X_W-1:0]           x_s1;
	logic signed [mmpd_pkg::Y_W-1:0]    y_s1;
	logic                               valid_s2;
	mmpd_pkg::bucket_t                  bkt_s2;

	// gap = bucket progress sum minus sample progress sum; it stays below N
	logic [mmpd_pkg::POS_W-1:0]         pos_q;
	logic [mmpd_pkg::POS_W-1:0]         gap_q;
	logic signed [mmpd_pkg::Y_W-1:0]    min_q;
	logic signed [mmpd_pkg::Y_W-1:0]    max_q;
	logic [mmpd_pkg::X_W-1:0]           first_x_q;

	logic adv_s1, adv_s2, fire;
	logic tot_zero, restart, in_win, at_start, empty, close, end_set;
	logic [mmpd_pkg::POS_W-1:0]      p, p_next, gap_b, gap_c, gap_n;
	logic [mmpd_pkg::POS_W:0]        gap_sum;
	logic signed [mmpd_pkg::Y_W-1:0] min_b, max_b, min_c, max_c, min_n, max_n;
	logic [mmpd_pkg::X_W-1:0]        first_x_n;

	assign adv_s2   = !valid_s2 || !bkt_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign fire     = valid_s1 && adv_s2;

	always_comb begin
		tot_zero = cfg.tot == '0;
		restart  = pos_q >= cfg.tot;
		p        = restart ? '0 : pos_q;
		gap_b    = restart ? '0 : gap_q;
		min_b    = restart ? mmpd_pkg::Y_POS_MAX : min_q;
		max_b    = restart ? mmpd_pkg::Y_NEG_MAX : max_q;
		in_win   = cfg.win_ok && (p >= cfg.ws) && (p < cfg.we);
		at_start = p == cfg.ws;
		gap_c    = at_start ? (cfg.n - cfg.b) : gap_b;
		min_c    = at_start ? mmpd_pkg::Y_POS_MAX : min_b;
		max_c    = at_start ? mmpd_pkg::Y_NEG_MAX : max_b;
		empty     = min_c > max_c;
		first_x_n = empty ? x_s1 : first_x_q;
		min_n     = (y_s1 < min_c) ? y_s1 : min_c;
		max_n     = (y_s1 > max_c) ? y_s1 : max_c;
		close     = !tot_zero && in_win && (cfg.b > gap_c);
		gap_sum   = {1'b0, gap_c} + (close ? {1'b0, cfg.n} : '0) - {1'b0, cfg.b};
		gap_n     = gap_sum[mmpd_pkg::POS_W-1:0];
		p_next    = p + 1'b1;
		end_set   = p_next >= cfg.tot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pos_q    <= '0;
			gap_q    <= '0;
			min_q    <= mmpd_pkg::Y_POS_MAX;
			max_q    <= mmpd_pkg::Y_NEG_MAX;
		end else begin
			if (adv_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= fire && close;
			if (fire) begin
				if (tot_zero) begin
					pos_q <= '0;
				end else if (end_set) begin
					pos_q <= '0;
					gap_q <= '0;
					min_q <= mmpd_pkg::Y_POS_MAX;
					max_q <= mmpd_pkg::Y_NEG_MAX;
				end else if (in_win) begin
					pos_q <= p_next;
					gap_q <= gap_n;
					min_q <= close ? mmpd_pkg::Y_POS_MAX : min_n;
					max_q <= close ? mmpd_pkg::Y_NEG_MAX : max_n;
				end else begin
					pos_q <= p_next;
					gap_q <= gap_b;
					min_q <= min_b;
					max_q <= max_b;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv_s1) begin
			x_s1 <= x_value;
			y_s1 <= y_value;
		end
		if (fire && !tot_zero && !end_set && in_win)
			first_x_q <= first_x_n;
		if (fire && close) begin
			bkt_s2.x_sum <= mmpd_pkg::XSUM_W'(first_x_n) + mmpd_pkg::XSUM_W'(x_s1);
			bkt_s2.y_min <= min_n;
			bkt_s2.y_max <= max_n;
			bkt_s2.last  <= p_next == cfg.we;
		end
	end

	assign bkt_valid = valid_s2;
	assign bkt       = bkt_s2;

endmodule

/* rtl/mmpd_scale.sv */
// Q8.8 scaling of a closed bucket: multiply stage, then bias, saturation
// and ordering into the output register. Depends on mmpd_pkg.
module mmpd_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mmpd_pkg::cfg_t                    cfg,
	input  logic                              bkt_valid,
	output logic                              bkt_stall,
	input  mmpd_pkg::bucket_t                 bkt,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [mmpd_pkg::XPT_W-1:0] x_point,
	output logic signed [mmpd_pkg::YOUT_W-1:0] y_low,
	output logic signed [mmpd_pkg::YOUT_W-1:0] y_high,
	output logic                              final_bucket
);

	localparam int XP_W = mmpd_pkg::XSUM_W + 1 + mmpd_pkg::GAIN_W;
	localparam int YP_W = mmpd_pkg::Y_W + mmpd_pkg::GAIN_W;
	localparam int YS_W = mmpd_pkg::YOUT_W + 2;

	function automatic logic signed [mmpd_pkg::YOUT_W-1:0] sat_y(
		input logic signed [YS_W-1:0] v);
		logic signed [mmpd_pkg::YOUT_W-1:0] r;
		if (v[YS_W-1:mmpd_pkg::YOUT_W-1] == '0 || v[YS_W-1:mmpd_pkg::YOUT_W-1] == '1)
			r = v[mmpd_pkg::YOUT_W-1:0];
		else if (v[YS_W-1])
			r = {1'b1, {(mmpd_pkg::YOUT_W-1){1'b0}}};
		else
			r = {1'b0, {(mmpd_pkg::YOUT_W-1){1'b1}}};
		return r;
	endfunction

	logic                        valid_s3;
	logic signed [XP_W-1:0]      px_s3;
	logic signed [YP_W-1:0]      pmin_s3;
	logic signed [YP_W-1:0]      pmax_s3;
	logic                        last_s3;
	logic                        out_valid_q;
	logic signed [mmpd_pkg::XPT_W-1:0]  x_point_q;
	logic signed [mmpd_pkg::YOUT_W-1:0] y_low_q, y_high_q;
	logic                        last_q;

	logic adv_o, adv_s3;
	logic signed [XP_W-1:0] xs_w, xg_w;
	logic signed [YP_W-1:0] ymin_w, ymax_w, yg_w;
	logic signed [mmpd_pkg::XPT_W-1:0]  x_res;
	logic signed [YS_W-1:0]             ya_sum, yb_sum;
	logic signed [mmpd_pkg::YOUT_W-1:0] ya, yb;

	assign adv_o     = !out_valid_q || !out_stall;
	assign adv_s3    = !valid_s3 || adv_o;
	assign bkt_stall = !adv_s3;

	always_comb begin
		xs_w   = XP_W'($signed({1'b0, bkt.x_sum}));
		xg_w   = XP_W'(cfg.x_gain);
		ymin_w = YP_W'(bkt.y_min);
		ymax_w = YP_W'(bkt.y_max);
		yg_w   = YP_W'(cfg.y_gain);
	end

	// arithmetic shifts give the floor of the Q8.8 products
	always_comb begin
		x_res  = mmpd_pkg::XPT_W'($signed(px_s3[XP_W-1:9]))
			+ mmpd_pkg::XPT_W'(cfg.x_bias);
		ya_sum = YS_W'($signed(pmin_s3[YP_W-1:8])) + YS_W'(cfg.y_bias);
		yb_sum = YS_W'($signed(pmax_s3[YP_W-1:8])) + YS_W'(cfg.y_bias);
		ya     = sat_y(ya_sum);
		yb     = sat_y(yb_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s3)
				valid_s3 <= bkt_valid;
			if (adv_o)
				out_valid_q <= valid_s3;
		end
	end

	// scaling is monotone, so a negative y gain alone swaps min and max
	always_ff @(posedge clk) begin
		if (bkt_valid && adv_s3) begin
			px_s3   <= xs_w * xg_w;
			pmin_s3 <= ymin_w * yg_w;
			pmax_s3 <= ymax_w * yg_w;
			last_s3 <= bkt.last;
		end
		if (valid_s3 && adv_o) begin
			x_point_q <= x_res;
			y_low_q   <= cfg.y_gain[mmpd_pkg::GAIN_W-1] ? yb : ya;
			y_high_q  <= cfg.y_gain[mmpd_pkg::GAIN_W-1] ? ya : yb;
			last_q    <= last_s3;
		end
	end

	assign out_valid    = out_valid_q;
	assign x_point      = x_point_q;
	assign y_low        = y_low_q;
	assign y_high       = y_high_q;
	assign final_bucket = last_q;

endmodule
